// ===== hdl/tmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tmc_pkg
// Shared types, constants and command structs of the tet mesh COM/energy core.
// -----------------------------------------------------------------------------
package tmc_pkg;

  localparam int unsigned VertBits  = 12;
  localparam int unsigned Depth     = 4096;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned PosBits   = 3 * CoordBits;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits   = 48;

  localparam logic [CfgIdxBits-1:0] RegTargetX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegTargetY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegTargetZ = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegProj0   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegProj1   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegProj2   = 3'd5;

  localparam logic OpVertex = 1'b0;
  localparam logic OpTet    = 1'b1;

  typedef struct packed {
    logic                        operation;
    logic [VertBits-1:0]         vertex_index;
    logic signed [15:0]          vertex_x;
    logic signed [15:0]          vertex_y;
    logic signed [15:0]          vertex_z;
    logic [VertBits-1:0]         corner_a;
    logic [VertBits-1:0]         corner_b;
    logic [VertBits-1:0]         corner_c;
    logic [VertBits-1:0]         corner_d;
    logic                        last_tet;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] com_x;
    logic signed [15:0] com_y;
    logic signed [15:0] com_z;
    logic [63:0]        energy;
    logic               zero_volume;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture input item
    logic       wr_vert;   // write vertex into store
    logic       rd_en;     // issue store read
    logic [1:0] rd_sel;    // corner being read
    logic       cap_en;    // capture read data
    logic [1:0] cap_sel;
    logic [3:0] step;      // arithmetic step
    logic       step_en;
    logic       div_start;
    logic [1:0] div_axis;
    logic       out_load;
    logic       clr_sums;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tet;
    logic last;
    logic div_done;
    logic vol_zero;
  } sts_t;

  function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sh0_7FFF_FFFF_FFFF_FFFF;
      mn = -66'sh0_8000_0000_0000_0000;
      if (v > mx) sat64 = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (v < mn) sat64 = 64'sh8000_0000_0000_0000;
      else sat64 = v[63:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tmc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tmc_ram
// Generic single-port RAM with registered read.
// -----------------------------------------------------------------------------
module tmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== hdl/tmc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tmc_div
// Signed 64/64 restoring divider, one quotient bit per cycle, truncating.
// -----------------------------------------------------------------------------
module tmc_div
  import tmc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [63:0] den_i,
  output logic                    done_o,
  output logic signed [63:0]      quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic        neg_q, neg_d, ovf_q, ovf_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;
  logic [63:0] mag;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; neg_d = neg_q; ovf_d = ovf_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[63] ? 64'd0 - num_i : num_i;
      dvs_d  = den_i[63] ? 64'd0 - den_i : den_i;
      neg_d  = num_i[63] ^ den_i[63];
      ovf_d  = (num_i == 64'sh8000_0000_0000_0000) && (den_i == -64'sd1);
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; neg_q <= neg_d; ovf_q <= ovf_d;
  end

  assign mag    = quo_q;
  assign done_o = done_q;
  assign quo_o  = ovf_q ? 64'sh7FFF_FFFF_FFFF_FFFF
                        : (neg_q ? $signed(64'd0 - mag) : $signed(mag));
endmodule
`default_nettype wire

// ===== hdl/tmc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tmc_datapath
// Position store, determinant and moment accumulation, COM division, energy.
// -----------------------------------------------------------------------------
module tmc_datapath
  import tmc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire in_item_t              in_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CfgBits-1:0]    cfg_data_i,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  output out_item_t                  out_o
);
  in_item_t item_q;
  logic signed [15:0] tgt_q [3];
  logic [47:0] proj_q [3];
  logic signed [63:0] msum_q [3];
  logic signed [63:0] vsum_q;
  logic signed [15:0] pos_q [4][3];
  logic [PosBits-1:0] rdata;
  logic [VertBits-1:0] raddr;
  logic signed [16:0] e1 [3], e2 [3], e3 [3];
  logic signed [17:0] s [3];
  logic signed [33:0] pr_q [6];
  logic signed [34:0] cr_q [3];
  logic signed [51:0] dt_q [3];
  logic signed [63:0] det, dq_q;
  logic signed [63:0] mterm_q [3];
  logic signed [15:0] com_q [3];
  logic signed [16:0] diff_q [3];
  logic signed [33:0] pp_q [3][3];
  logic signed [35:0] prow_q [3];
  logic signed [21:0] qv [3];
  logic [43:0] sq_q [3];
  logic [63:0] energy_q;
  logic div_done;
  logic signed [63:0] quo, q4;
  logic signed [63:0] mclip;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q[0] <= '0; tgt_q[1] <= '0; tgt_q[2] <= '0;
      proj_q[0] <= 48'd16384;
      proj_q[1] <= 48'd1073741824;
      proj_q[2] <= 48'd70368744177664;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTargetX: tgt_q[0] <= cfg_data_i[15:0];
        RegTargetY: tgt_q[1] <= cfg_data_i[15:0];
        RegTargetZ: tgt_q[2] <= cfg_data_i[15:0];
        RegProj0:   proj_q[0] <= cfg_data_i;
        RegProj1:   proj_q[1] <= cfg_data_i;
        RegProj2:   proj_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      2'd0: raddr = item_q.corner_a;
      2'd1: raddr = item_q.corner_b;
      2'd2: raddr = item_q.corner_c;
      default: raddr = item_q.corner_d;
    endcase
    if (cmd_i.wr_vert) raddr = item_q.vertex_index;
  end

  tmc_ram #(.Width(PosBits), .Depth(Depth)) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_vert),
    .re_i   (cmd_i.rd_en),
    .addr_i (raddr),
    .wdata_i({item_q.vertex_z, item_q.vertex_y, item_q.vertex_x}),
    .rdata_o(rdata)
  );

  tmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (msum_q[cmd_i.div_axis]),
    .den_i  (vsum_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = 17'(pos_q[1][k]) - 17'(pos_q[0][k]);
      e2[k] = 17'(pos_q[2][k]) - 17'(pos_q[0][k]);
      e3[k] = 17'(pos_q[3][k]) - 17'(pos_q[0][k]);
      s[k]  = 18'(pos_q[0][k]) + 18'(pos_q[1][k]) + 18'(pos_q[2][k]) + 18'(pos_q[3][k]);
    end
    det = 64'(dt_q[0]) + 64'(dt_q[1]) + 64'(dt_q[2]);
    for (int k = 0; k < 3; k++) qv[k] = prow_q[k][35:14];
    // truncate toward zero then divide by 4 toward zero
    q4 = (quo + (quo[63] ? 64'sd3 : 64'sd0)) >>> 2;
    if (q4 > 64'sd32767) mclip = 64'sd32767;
    else if (q4 < -64'sd32768) mclip = -64'sd32768;
    else mclip = q4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsum_q <= '0;
      msum_q[0] <= '0; msum_q[1] <= '0; msum_q[2] <= '0;
    end else if (cmd_i.clr_sums) begin
      vsum_q <= '0;
      msum_q[0] <= '0; msum_q[1] <= '0; msum_q[2] <= '0;
    end else if (cmd_i.step_en && cmd_i.step == 4'd4) begin
      vsum_q <= sat64(66'(vsum_q) + 66'(dq_q));
      for (int k = 0; k < 3; k++) msum_q[k] <= sat64(66'(msum_q[k]) + 66'(mterm_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.cap_en) begin
      pos_q[cmd_i.cap_sel][0] <= rdata[15:0];
      pos_q[cmd_i.cap_sel][1] <= rdata[31:16];
      pos_q[cmd_i.cap_sel][2] <= rdata[47:32];
    end
    if (div_done) com_q[cmd_i.div_axis] <= mclip[15:0];
    if (cmd_i.step_en) begin
      unique case (cmd_i.step)
        4'd0: begin
          pr_q[0] <= e1[1] * e2[2]; pr_q[1] <= e1[2] * e2[1];
          pr_q[2] <= e1[2] * e2[0]; pr_q[3] <= e1[0] * e2[2];
          pr_q[4] <= e1[0] * e2[1]; pr_q[5] <= e1[1] * e2[0];
        end
        4'd1: begin
          cr_q[0] <= 35'(pr_q[0]) - 35'(pr_q[1]);
          cr_q[1] <= 35'(pr_q[2]) - 35'(pr_q[3]);
          cr_q[2] <= 35'(pr_q[4]) - 35'(pr_q[5]);
        end
        4'd2: for (int k = 0; k < 3; k++) dt_q[k] <= e3[k] * cr_q[k];
        4'd3: dq_q <= det >>> 16;
        4'd5: begin
          // dq stays within 36 bits for 16-bit coordinates
          for (int k = 0; k < 3; k++) mterm_q[k] <= 64'($signed(dq_q[39:0]) * s[k]);
        end
        4'd6: for (int k = 0; k < 3; k++) diff_q[k] <= 17'(com_q[k]) - 17'(tgt_q[k]);
        4'd7: for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                  pp_q[i][j] <= $signed(proj_q[i][16*j +: 16]) * diff_q[j];
        4'd8: for (int i = 0; i < 3; i++)
                prow_q[i] <= 36'(pp_q[i][0]) + 36'(pp_q[i][1]) + 36'(pp_q[i][2]);
        4'd9: for (int k = 0; k < 3; k++) sq_q[k] <= 44'(qv[k] * qv[k]);
        4'd10: energy_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      if (vsum_q == 64'sd0) begin
        out_q <= '0;
        out_q.zero_volume <= 1'b1;
      end else begin
        out_q.com_x <= com_q[0];
        out_q.com_y <= com_q[1];
        out_q.com_z <= com_q[2];
        out_q.energy <= energy_q;
        out_q.zero_volume <= 1'b0;
      end
    end
  end

  assign sts_o.is_tet   = item_q.operation == OpTet;
  assign sts_o.last     = item_q.last_tet;
  assign sts_o.div_done = div_done;
  assign sts_o.vol_zero = vsum_q == 64'sd0;
  assign out_o = out_q;
endmodule
`default_nettype wire

// ===== hdl/tmc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tmc_ctrl
// Sequencer: store reads, arithmetic steps, divisions and output handshake.
// -----------------------------------------------------------------------------
module tmc_ctrl
  import tmc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDisp = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SCalc = 3'd3;
  localparam logic [2:0] SDiv  = 3'd4;
  localparam logic [2:0] SWait = 3'd5;
  localparam logic [2:0] SEng  = 3'd6;
  localparam logic [2:0] SOut  = 3'd7;

  logic [2:0] st_q, st_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;
  logic       ov_q, ov_d;
  logic       acc;

  assign in_stall_o  = (st_q != SIdle) || ov_q;
  assign out_valid_o = ov_q;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ax_d = ax_q;
    ov_d = ov_q && out_stall_i;
    cmd_o = '0;
    cmd_o.div_axis = ax_q;
    cmd_o.load = acc;
    unique case (st_q)
      SIdle: if (acc) st_d = SDisp;
      SDisp: begin
        if (!sts_i.is_tet) begin
          cmd_o.wr_vert = 1'b1;
          st_d = SIdle;
        end else begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_sel = 2'd0;
          cnt_d = 4'd1;
          st_d = SRead;
        end
      end
      SRead: begin
        cmd_o.cap_en = 1'b1;
        cmd_o.cap_sel = 2'(cnt_q - 4'd1);
        cmd_o.rd_en = cnt_q != 4'd4;
        cmd_o.rd_sel = cnt_q[1:0];
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd4) begin
          cnt_d = 4'd0;
          st_d = SCalc;
        end
      end
      SCalc: begin
        cmd_o.step_en = 1'b1;
        cmd_o.step = (cnt_q == 4'd4) ? 4'd5 : ((cnt_q == 4'd5) ? 4'd4 : cnt_q);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) begin
          if (!sts_i.last) st_d = SIdle;
          else begin
            ax_d = 2'd0;
            st_d = SDiv;
          end
        end
      end
      SDiv: begin
        if (sts_i.vol_zero) begin
          cmd_o.out_load = 1'b1; cmd_o.clr_sums = 1'b1;
          ov_d = 1'b1; st_d = SIdle;
        end else begin
          cmd_o.div_start = 1'b1;
          st_d = SWait;
        end
      end
      SWait: if (sts_i.div_done) begin
        if (ax_q == 2'd2) begin
          cnt_d = 4'd6; st_d = SEng;
        end else begin
          ax_d = ax_q + 2'd1; st_d = SDiv;
        end
      end
      SEng: begin
        cmd_o.step_en = 1'b1;
        cmd_o.step = cnt_q;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd10) st_d = SOut;
      end
      SOut: begin
        cmd_o.out_load = 1'b1; cmd_o.clr_sums = 1'b1;
        ov_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; ax_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ax_q <= ax_d; ov_q <= ov_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tet_mesh_center_of_mass_energy_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Vertex item: a single store write. Tet item: four registered store reads
//   from the single-port position RAM, then six arithmetic steps.
// Last tet: then a bit-serial 64-bit divide per axis and the energy steps, unless the volume sum is zero.
// One item at a time; result held in an output register until transferred.
// Reset (async, active low) clears the sums, targets and projection to identity;
//   the position store is not cleared.
// -----------------------------------------------------------------------------
// tet_mesh_center_of_mass_energy_core
// Tetrahedral mesh center of mass and projected energy accumulator.
// -----------------------------------------------------------------------------
module tet_mesh_center_of_mass_energy_core
  import tmc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CfgBits-1:0]    cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  tmc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  tmc_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_volume |-> out_data_o.energy == 64'd0)
    else $error("zero volume result with nonzero energy");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> sts.vol_zero)
    else $error("sums not cleared after result");
endmodule
`default_nettype wire
